/* sv/wyh_pkg.sv */
// wyhash stream hasher shared types, constants and helpers
`timescale 1ns / 1ps
package wyh_pkg;

  localparam logic [63:0] SECRET0 = 64'ha0761d6478bd642f;
  localparam logic [63:0] SECRET1 = 64'he7037ed1a0b428db;
  localparam logic [63:0] SECRET2 = 64'h8ebc6af09c88c6e3;
  localparam logic [63:0] SECRET3 = 64'h589965cc75374cc3;

  localparam int WIN_DEPTH = 64;
  localparam int WIN_AW = 6;
  localparam int BLOCK_BYTES = 48;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT_GO,
    ST_INIT_WAIT,
    ST_MIX_LDA,
    ST_MIX_LDB,
    ST_MIX_GO,
    ST_MIX_WAIT,
    ST_FIN_SEL,
    ST_P3_L1,
    ST_P3_L2,
    ST_P3_L3,
    ST_P3_Z,
    ST_S_LA1,
    ST_S_LA2,
    ST_S_LB1,
    ST_S_LB2,
    ST_LOOP_CHK,
    ST_L_LDA,
    ST_L_LDB,
    ST_L_GO,
    ST_L_WAIT,
    ST_T_LA,
    ST_T_LB,
    ST_FIN1_GO,
    ST_FIN1_WAIT,
    ST_FIN2_GO,
    ST_FIN2_WAIT,
    ST_OUT_LD
  } wyh_state_t;

  typedef enum logic [2:0] {
    AB_ZERO,
    AB_MIX,
    AB_LEN,
    AB_HALF,
    AB_Q,
    AB_LENQ,
    AB_OFF
  } wyh_abase_t;

  typedef enum logic [1:0] {
    AS_SEED,
    AS_SEC,
    AS_S1,
    AS_PLAIN
  } wyh_asel_t;

  typedef enum logic [1:0] {
    BS_S1,
    BS_LANE,
    BS_ST,
    BS_PLAIN
  } wyh_bsel_t;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_INIT,
    CAP_LANE,
    CAP_ST,
    CAP_FIN1,
    CAP_FIN2
  } wyh_cap_t;

  typedef enum logic {
    LD_A,
    LD_B
  } wyh_dst_t;

  typedef struct packed {
    logic       take;
    logic       rd;
    wyh_dst_t   ld_dst;
    logic       ld_zero;
    wyh_abase_t abase;
    logic [5:0] off6;
    logic [2:0] idx;
    logic [1:0] lane;
    logic       clr_ab;
    logic       st_load;
    logic       mul_go;
    wyh_asel_t  asel;
    wyh_bsel_t  bsel;
    wyh_cap_t   cap;
    logic       out_load;
  } wyh_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic mix_need;
    logic len_zero;
    logic len_lt4;
    logic len_le16;
    logic loop_more;
    logic mul_done;
  } wyh_stat_t;

  function automatic logic [63:0] lane_secret(input logic [1:0] k);
    logic [63:0] s;
    case (k)
      2'd0: s = SECRET1;
      2'd1: s = SECRET2;
      default: s = SECRET3;
    endcase
    return s;
  endfunction

endpackage

/* sv/wyh_ram.sv */
// generic single write, single registered read ram
`timescale 1ns / 1ps
module wyh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/wyh_mul.sv */
// 64x64 to 128 multiplier, one 32x32 partial product per cycle
`timescale 1ns / 1ps
module wyh_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] lo,
  output logic [63:0] hi,
  output logic        done
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [1:0]   pp_sel;
  logic [2:0]   cnt;
  logic         busy;
  logic [31:0]  x_part;
  logic [31:0]  y_part;
  logic [1:0]   sh;
  logic [127:0] pp_shifted;

  assign x_part = cnt[0] ? a_r[63:32] : a_r[31:0];
  assign y_part = cnt[1] ? b_r[63:32] : b_r[31:0];
  assign sh = {1'b0, pp_sel[0]} + {1'b0, pp_sel[1]};
  assign pp_shifted = {64'd0, pp} << {sh, 5'd0};
  assign lo = acc[63:0];
  assign hi = acc[127:64];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 3'd4);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (busy) begin
      if (cnt != 3'd4) begin
        pp     <= x_part * y_part;
        pp_sel <= cnt[1:0];
      end
      if (cnt != 3'd0) begin
        acc <= acc + pp_shifted;
      end
    end
  end

endmodule

/* sv/wyh_dp.sv */
// hasher datapath: byte window, lanes, operands, counters and result register
`timescale 1ns / 1ps
module wyh_dp #(
  parameter int LENGTH_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [63:0]       seed,
  input  logic [7:0]        data_byte,
  input  logic              empty_req,
  input  wyh_pkg::wyh_cmd_t cmd,
  output wyh_pkg::wyh_stat_t stat,
  output logic [63:0]       hash,
  output logic              length_overflow
);

  localparam int LB = LENGTH_BITS;

  logic [LB-1:0] count;
  logic [LB-1:0] blk_off;
  logic [LB-1:0] off;
  logic          sat;
  logic [5:0]    phase;
  logic [5:0]    mix_base;
  logic          full;

  logic [63:0] lane_main;
  logic [63:0] lane_second;
  logic [63:0] lane_third;
  logic [63:0] st;
  logic [63:0] opa;
  logic [63:0] opb;

  logic                  rd_q;
  wyh_pkg::wyh_dst_t     dst_q;
  logic                  zero_q;
  logic [7:0]            rdata;
  logic [7:0]            shift_byte;
  logic                  we;
  logic [5:0]            len6;
  logic [5:0]            q6;
  logic [5:0]            base6;
  logic [5:0]            raddr;

  logic [63:0] lane_k;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] mul_lo;
  logic [63:0] mul_hi;
  logic        mul_done;
  logic [63:0] fold;

  assign full = &count;
  assign we = cmd.take && !empty_req && !full;
  assign len6 = count[5:0];
  assign q6 = {2'b00, len6[4:3], 2'b00};

  always_comb begin
    unique case (cmd.abase)
      wyh_pkg::AB_ZERO: base6 = 6'd0;
      wyh_pkg::AB_MIX:  base6 = mix_base;
      wyh_pkg::AB_LEN:  base6 = len6;
      wyh_pkg::AB_HALF: base6 = {1'b0, len6[5:1]};
      wyh_pkg::AB_Q:    base6 = q6;
      wyh_pkg::AB_LENQ: base6 = len6 - q6;
      wyh_pkg::AB_OFF:  base6 = off[5:0];
      default:          base6 = 6'd0;
    endcase
  end

  assign raddr = base6 + cmd.off6 + {3'b000, cmd.idx};
  assign shift_byte = zero_q ? 8'd0 : rdata;

  wyh_ram #(
    .WIDTH(8),
    .DEPTH(wyh_pkg::WIN_DEPTH)
  ) u_win (
    .clk  (clk),
    .we   (we),
    .waddr(count[wyh_pkg::WIN_AW-1:0]),
    .wdata(data_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    case (cmd.lane)
      2'd0: lane_k = lane_main;
      2'd1: lane_k = lane_second;
      default: lane_k = lane_third;
    endcase
  end

  always_comb begin
    unique case (cmd.asel)
      wyh_pkg::AS_SEED:  mul_a = seed ^ wyh_pkg::SECRET0;
      wyh_pkg::AS_SEC:   mul_a = opa ^ wyh_pkg::lane_secret(cmd.lane);
      wyh_pkg::AS_S1:    mul_a = opa ^ wyh_pkg::SECRET1;
      wyh_pkg::AS_PLAIN: mul_a = opa;
      default:           mul_a = opa;
    endcase
    unique case (cmd.bsel)
      wyh_pkg::BS_S1:    mul_b = wyh_pkg::SECRET1;
      wyh_pkg::BS_LANE:  mul_b = opb ^ lane_k;
      wyh_pkg::BS_ST:    mul_b = opb ^ st;
      wyh_pkg::BS_PLAIN: mul_b = opb;
      default:           mul_b = opb;
    endcase
  end

  wyh_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .lo   (mul_lo),
    .hi   (mul_hi),
    .done (mul_done)
  );

  assign fold = mul_lo ^ mul_hi;

  assign stat.cnt_zero = (count == '0);
  assign stat.mix_need = !empty_req && !full && (count != '0) && (phase == 6'd0);
  assign stat.len_zero = (count == '0);
  assign stat.len_lt4 = (count < LB'(4));
  assign stat.len_le16 = (count <= LB'(16));
  assign stat.loop_more = ({1'b0, off} + (LB + 1)'(16)) < {1'b0, count};
  assign stat.mul_done = mul_done;

  // counters and window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sat     <= 1'b0;
      phase   <= '0;
      blk_off <= '0;
      rd_q    <= 1'b0;
    end else begin
      rd_q <= cmd.rd;
      if (cmd.out_load) begin
        count   <= '0;
        sat     <= 1'b0;
        phase   <= '0;
        blk_off <= '0;
      end else if (cmd.take && !empty_req) begin
        if (full) begin
          sat <= 1'b1;
        end else begin
          count <= count + LB'(1);
          phase <= (phase == 6'(wyh_pkg::BLOCK_BYTES - 1)) ? 6'd0 : phase + 6'd1;
          if (stat.mix_need) begin
            blk_off <= count;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dst_q  <= cmd.ld_dst;
    zero_q <= cmd.ld_zero;
    if (cmd.take && stat.mix_need) begin
      mix_base <= len6 - 6'(wyh_pkg::BLOCK_BYTES);
    end
    if (cmd.st_load) begin
      st  <= stat.len_le16 ? lane_main : (lane_main ^ lane_second ^ lane_third);
      off <= blk_off;
    end else if (mul_done && (cmd.cap == wyh_pkg::CAP_ST)) begin
      st  <= fold;
      off <= off + LB'(16);
    end
    if (cmd.clr_ab) begin
      opa <= '0;
      opb <= '0;
    end else if (rd_q) begin
      if (dst_q == wyh_pkg::LD_A) begin
        opa <= {shift_byte, opa[63:8]};
      end else begin
        opb <= {shift_byte, opb[63:8]};
      end
    end else if (mul_done && (cmd.cap == wyh_pkg::CAP_FIN1)) begin
      opa <= mul_lo ^ wyh_pkg::SECRET0 ^ 64'(count);
      opb <= mul_hi ^ wyh_pkg::SECRET1;
    end else if (mul_done && (cmd.cap == wyh_pkg::CAP_FIN2)) begin
      opa <= fold;
    end
    if (mul_done && (cmd.cap == wyh_pkg::CAP_INIT)) begin
      lane_main   <= seed ^ fold;
      lane_second <= seed ^ fold;
      lane_third  <= seed ^ fold;
    end else if (mul_done && (cmd.cap == wyh_pkg::CAP_LANE)) begin
      case (cmd.lane)
        2'd0: lane_main <= fold;
        2'd1: lane_second <= fold;
        default: lane_third <= fold;
      endcase
    end
    if (cmd.out_load) begin
      hash            <= opa;
      length_overflow <= sat;
    end
  end

endmodule

/* sv/wyh_ctrl.sv */
// hasher controller: message sequencing, window loads, multiply steps, output slot
`timescale 1ns / 1ps
module wyh_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               last,
  input  logic               empty_req,
  input  logic               out_stall,
  input  wyh_pkg::wyh_stat_t stat,
  output logic               in_stall,
  output logic               out_valid,
  output wyh_pkg::wyh_cmd_t  cmd
);

  wyh_pkg::wyh_state_t state;
  wyh_pkg::wyh_state_t state_next;
  logic [3:0] idx;
  logic [3:0] ld_n;
  logic [1:0] k;
  logic       last_pend;
  logic       take;
  logic       do_init;
  logic       slot_free;

  assign in_stall = (state != wyh_pkg::ST_IDLE);
  assign take = in_valid && !in_stall;
  assign do_init = stat.cnt_zero && (!empty_req || last);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    unique case (state)
      wyh_pkg::ST_MIX_LDA, wyh_pkg::ST_MIX_LDB, wyh_pkg::ST_L_LDA, wyh_pkg::ST_L_LDB,
      wyh_pkg::ST_T_LA, wyh_pkg::ST_T_LB: ld_n = 4'd8;
      wyh_pkg::ST_P3_L1, wyh_pkg::ST_P3_L2, wyh_pkg::ST_P3_L3: ld_n = 4'd1;
      wyh_pkg::ST_P3_Z: ld_n = 4'd5;
      wyh_pkg::ST_S_LA1, wyh_pkg::ST_S_LA2, wyh_pkg::ST_S_LB1, wyh_pkg::ST_S_LB2: ld_n = 4'd4;
      default: ld_n = 4'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wyh_pkg::ST_IDLE;
      idx       <= '0;
      k         <= '0;
      last_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ld_n != 4'd0) begin
        idx <= (idx == ld_n) ? 4'd0 : idx + 4'd1;
      end else begin
        idx <= '0;
      end
      if (take) begin
        k         <= '0;
        last_pend <= last;
      end else if ((state == wyh_pkg::ST_MIX_WAIT) && stat.mul_done && (k != 2'd2)) begin
        k <= k + 2'd1;
      end
      if ((state == wyh_pkg::ST_OUT_LD) && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wyh_pkg::ST_IDLE: begin
        if (take) begin
          if (do_init) begin
            state_next = wyh_pkg::ST_INIT_GO;
          end else if (stat.mix_need) begin
            state_next = wyh_pkg::ST_MIX_LDA;
          end else if (last) begin
            state_next = wyh_pkg::ST_FIN_SEL;
          end
        end
      end
      wyh_pkg::ST_INIT_GO: state_next = wyh_pkg::ST_INIT_WAIT;
      wyh_pkg::ST_INIT_WAIT: begin
        if (stat.mul_done) begin
          state_next = last_pend ? wyh_pkg::ST_FIN_SEL : wyh_pkg::ST_IDLE;
        end
      end
      wyh_pkg::ST_MIX_LDA: if (idx == ld_n) state_next = wyh_pkg::ST_MIX_LDB;
      wyh_pkg::ST_MIX_LDB: if (idx == ld_n) state_next = wyh_pkg::ST_MIX_GO;
      wyh_pkg::ST_MIX_GO: state_next = wyh_pkg::ST_MIX_WAIT;
      wyh_pkg::ST_MIX_WAIT: begin
        if (stat.mul_done) begin
          if (k != 2'd2) begin
            state_next = wyh_pkg::ST_MIX_LDA;
          end else begin
            state_next = last_pend ? wyh_pkg::ST_FIN_SEL : wyh_pkg::ST_IDLE;
          end
        end
      end
      wyh_pkg::ST_FIN_SEL: begin
        if (stat.len_zero) begin
          state_next = wyh_pkg::ST_FIN1_GO;
        end else if (stat.len_lt4) begin
          state_next = wyh_pkg::ST_P3_L1;
        end else if (stat.len_le16) begin
          state_next = wyh_pkg::ST_S_LA1;
        end else begin
          state_next = wyh_pkg::ST_LOOP_CHK;
        end
      end
      wyh_pkg::ST_P3_L1: if (idx == ld_n) state_next = wyh_pkg::ST_P3_L2;
      wyh_pkg::ST_P3_L2: if (idx == ld_n) state_next = wyh_pkg::ST_P3_L3;
      wyh_pkg::ST_P3_L3: if (idx == ld_n) state_next = wyh_pkg::ST_P3_Z;
      wyh_pkg::ST_P3_Z:  if (idx == ld_n) state_next = wyh_pkg::ST_FIN1_GO;
      wyh_pkg::ST_S_LA1: if (idx == ld_n) state_next = wyh_pkg::ST_S_LA2;
      wyh_pkg::ST_S_LA2: if (idx == ld_n) state_next = wyh_pkg::ST_S_LB1;
      wyh_pkg::ST_S_LB1: if (idx == ld_n) state_next = wyh_pkg::ST_S_LB2;
      wyh_pkg::ST_S_LB2: if (idx == ld_n) state_next = wyh_pkg::ST_FIN1_GO;
      wyh_pkg::ST_LOOP_CHK: begin
        state_next = stat.loop_more ? wyh_pkg::ST_L_LDA : wyh_pkg::ST_T_LA;
      end
      wyh_pkg::ST_L_LDA: if (idx == ld_n) state_next = wyh_pkg::ST_L_LDB;
      wyh_pkg::ST_L_LDB: if (idx == ld_n) state_next = wyh_pkg::ST_L_GO;
      wyh_pkg::ST_L_GO: state_next = wyh_pkg::ST_L_WAIT;
      wyh_pkg::ST_L_WAIT: if (stat.mul_done) state_next = wyh_pkg::ST_LOOP_CHK;
      wyh_pkg::ST_T_LA: if (idx == ld_n) state_next = wyh_pkg::ST_T_LB;
      wyh_pkg::ST_T_LB: if (idx == ld_n) state_next = wyh_pkg::ST_FIN1_GO;
      wyh_pkg::ST_FIN1_GO: state_next = wyh_pkg::ST_FIN1_WAIT;
      wyh_pkg::ST_FIN1_WAIT: if (stat.mul_done) state_next = wyh_pkg::ST_FIN2_GO;
      wyh_pkg::ST_FIN2_GO: state_next = wyh_pkg::ST_FIN2_WAIT;
      wyh_pkg::ST_FIN2_WAIT: if (stat.mul_done) state_next = wyh_pkg::ST_OUT_LD;
      wyh_pkg::ST_OUT_LD: if (slot_free) state_next = wyh_pkg::ST_IDLE;
      default: state_next = wyh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.take     = take;
    cmd.ld_dst   = wyh_pkg::LD_A;
    cmd.abase    = wyh_pkg::AB_ZERO;
    cmd.asel     = wyh_pkg::AS_PLAIN;
    cmd.bsel     = wyh_pkg::BS_PLAIN;
    cmd.cap      = wyh_pkg::CAP_NONE;
    cmd.lane     = k;
    cmd.idx      = idx[2:0];
    cmd.rd       = (ld_n != 4'd0) && (idx < ld_n);
    unique case (state)
      wyh_pkg::ST_IDLE: ;
      wyh_pkg::ST_INIT_GO: begin
        cmd.mul_go = 1'b1;
        cmd.asel   = wyh_pkg::AS_SEED;
        cmd.bsel   = wyh_pkg::BS_S1;
      end
      wyh_pkg::ST_INIT_WAIT: if (stat.mul_done) cmd.cap = wyh_pkg::CAP_INIT;
      wyh_pkg::ST_MIX_LDA: begin
        cmd.abase = wyh_pkg::AB_MIX;
        cmd.off6  = {k, 4'b0000};
      end
      wyh_pkg::ST_MIX_LDB: begin
        cmd.ld_dst = wyh_pkg::LD_B;
        cmd.abase  = wyh_pkg::AB_MIX;
        cmd.off6   = {k, 4'b1000};
      end
      wyh_pkg::ST_MIX_GO: begin
        cmd.mul_go = 1'b1;
        cmd.asel   = wyh_pkg::AS_SEC;
        cmd.bsel   = wyh_pkg::BS_LANE;
      end
      wyh_pkg::ST_MIX_WAIT: if (stat.mul_done) cmd.cap = wyh_pkg::CAP_LANE;
      wyh_pkg::ST_FIN_SEL: begin
        cmd.st_load = 1'b1;
        cmd.clr_ab  = 1'b1;
      end
      wyh_pkg::ST_P3_L1: begin
        cmd.abase = wyh_pkg::AB_LEN;
        cmd.off6  = 6'd63;
      end
      wyh_pkg::ST_P3_L2: cmd.abase = wyh_pkg::AB_HALF;
      wyh_pkg::ST_P3_L3: cmd.abase = wyh_pkg::AB_ZERO;
      wyh_pkg::ST_P3_Z: cmd.ld_zero = 1'b1;
      wyh_pkg::ST_S_LA1: cmd.abase = wyh_pkg::AB_Q;
      wyh_pkg::ST_S_LA2: cmd.abase = wyh_pkg::AB_ZERO;
      wyh_pkg::ST_S_LB1: begin
        cmd.ld_dst = wyh_pkg::LD_B;
        cmd.abase  = wyh_pkg::AB_LENQ;
        cmd.off6   = 6'd60;
      end
      wyh_pkg::ST_S_LB2: begin
        cmd.ld_dst = wyh_pkg::LD_B;
        cmd.abase  = wyh_pkg::AB_LEN;
        cmd.off6   = 6'd60;
      end
      wyh_pkg::ST_LOOP_CHK: ;
      wyh_pkg::ST_L_LDA: cmd.abase = wyh_pkg::AB_OFF;
      wyh_pkg::ST_L_LDB: begin
        cmd.ld_dst = wyh_pkg::LD_B;
        cmd.abase  = wyh_pkg::AB_OFF;
        cmd.off6   = 6'd8;
      end
      wyh_pkg::ST_L_GO: begin
        cmd.mul_go = 1'b1;
        cmd.asel   = wyh_pkg::AS_S1;
        cmd.bsel   = wyh_pkg::BS_ST;
      end
      wyh_pkg::ST_L_WAIT: if (stat.mul_done) cmd.cap = wyh_pkg::CAP_ST;
      wyh_pkg::ST_T_LA: begin
        cmd.abase = wyh_pkg::AB_LEN;
        cmd.off6  = 6'd48;
      end
      wyh_pkg::ST_T_LB: begin
        cmd.ld_dst = wyh_pkg::LD_B;
        cmd.abase  = wyh_pkg::AB_LEN;
        cmd.off6   = 6'd56;
      end
      wyh_pkg::ST_FIN1_GO: begin
        cmd.mul_go = 1'b1;
        cmd.asel   = wyh_pkg::AS_S1;
        cmd.bsel   = wyh_pkg::BS_ST;
      end
      wyh_pkg::ST_FIN1_WAIT: if (stat.mul_done) cmd.cap = wyh_pkg::CAP_FIN1;
      wyh_pkg::ST_FIN2_GO: cmd.mul_go = 1'b1;
      wyh_pkg::ST_FIN2_WAIT: if (stat.mul_done) cmd.cap = wyh_pkg::CAP_FIN2;
      wyh_pkg::ST_OUT_LD: cmd.out_load = slot_free;
      default: ;
    endcase
  end

endmodule

/* sv/wyhash_stream_hasher.sv */
// wyhash stream hasher top level: apb seed register, controller and datapath
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   data_byte, last, empty_req
//  out      source     out_valid / out_stall hash, length_overflow
//  cfg      apb slave  psel/penable/pready   seed at address 0
//
// a first byte starts the seed multiply; the byte after each full 48-byte block
// starts the lane mix, three multiplies; at end of message a message over 16
// bytes runs one multiply per 16-byte block before the tail loads and the two
// final multiplies
// in_stall is high whenever the controller is busy; a finished hash waits in
// the output register while the next message streams in
// synchronous reset clears control state; window contents are not cleared
`timescale 1ns / 1ps
module wyhash_stream_hasher #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic        empty_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash,
  output logic        length_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0]        seed;
  wyh_pkg::wyh_cmd_t  cmd;
  wyh_pkg::wyh_stat_t stat;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? 64'd0 : seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[3]) begin
      seed <= pwdata;
    end
  end

  wyh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .empty_req(empty_req),
    .out_stall(out_stall),
    .stat     (stat),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  wyh_dp #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .seed           (seed),
    .data_byte      (data_byte),
    .empty_req      (empty_req),
    .cmd            (cmd),
    .stat           (stat),
    .hash           (hash),
    .length_overflow(length_overflow)
  );

  a_mul_multicycle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_go |=> !stat.mul_done)
    else $error("multiplier finished one cycle after start");

  a_product_used: assert property (@(posedge clk) disable iff (rst)
    stat.mul_done |-> (cmd.cap != wyh_pkg::CAP_NONE))
    else $error("multiplier result dropped");

  a_first_byte_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && stat.cnt_zero && !empty_req) |=> in_stall)
    else $error("first byte beat did not start seed mix");

endmodule
